>>> rtl/masked_byte_pattern_scan_defines.svh
// Assertion macros shared by the RTL. They sample on clk and are disabled in reset.
`ifndef MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mbps_pkg.sv
`default_nettype none
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int WIN_IDX_W = $clog2(MAX_PATTERN_BYTES);
    localparam int LEN_W = 5;
    localparam int OFFSET_W = 32;

    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_PATTERN_LOW  = 2'd0;
    localparam reg_index_t REG_PATTERN_HIGH = 2'd1;
    localparam reg_index_t REG_CARE_BITS    = 2'd2;
    localparam reg_index_t REG_PATTERN_LEN  = 2'd3;

    // Control that every window cell receives each cycle.
    typedef struct packed {
        logic shift_en;
        logic clear;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/mbps_cell.sv
`default_nettype none
module mbps_cell
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mbps_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]        byte_in,
    input  wire logic [7:0]        expect_byte,
    input  wire logic              care,
    output logic [7:0]             byte_out,
    output logic                   match
);
    import mbps_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // After a shift this cell holds byte_in, so the compare looks at it directly.
    assign match = !care || (byte_in == expect_byte);
    assign byte_out = byte_reg;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'd0;
        end
        else if (ctrl.shift_en)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/masked_byte_pattern_scan.sv
// Masked byte pattern scan.
// Bytes of a region enter on the s_ channel, one per transaction: s_tdata holds
// the byte and s_tlast marks the last byte of the region. The user sets the
// pattern, care mask and length over APB only while idle (not enforced).
// A row of sixteen window cells holds the latest bytes and compares all pattern
// positions in parallel, so the block takes one byte per cycle unless stalled.
// At most one result per region leaves on the m_ channel: m_tuser is the found
// flag and m_tdata the start offset of the match (zero when not found). The
// result appears the cycle after the byte that completes the match, or after
// the last byte when there is no match. Later bytes of a matched region are
// absorbed without a result.
// The result sits in an output register; while a result waits there and the
// receiver stalls, s_tready is low and no byte is taken, so every cycle of
// stall on the m_ channel also holds the s_ channel.
// Reset clears the window, the byte count and the configuration to its
// defaults (care mask all ones, length one).
`default_nettype none
`include "masked_byte_pattern_scan_defines.svh"
module masked_byte_pattern_scan
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    // Byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // region_end
    // Result out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] match_offset
    output logic             m_tuser    // [0] found
);
    import mbps_pkg::*;

    logic [63:0]        pattern_low_reg;
    logic [63:0]        pattern_high_reg;
    logic [15:0]        care_bits_reg;
    logic [LEN_W-1:0]   pattern_length_reg;

    logic [OFFSET_W-1:0] bytes_seen_reg;
    logic [OFFSET_W-1:0] bytes_seen_next;
    logic                match_reported_reg;
    logic                match_reported_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_found_reg;
    logic                out_found_next;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [OFFSET_W-1:0] out_offset_next;

    logic                cfg_write;
    reg_index_t          cfg_index;
    logic                in_fire;
    logic [LEN_W-1:0]    len_eff;
    logic [LEN_W-1:0]    len_sub;
    logic [OFFSET_W:0]   count;
    logic [OFFSET_W:0]   offset_wide;
    logic                all_match;
    logic                hit;
    logic                produce;
    logic [127:0]        pattern_all;
    cell_ctrl_t          cell_ctrl;

    logic [7:0] win [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] cell_match;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:3];

    always_comb
    begin
        unique case (cfg_index)
            REG_PATTERN_LOW:  prdata = pattern_low_reg;
            REG_PATTERN_HIGH: prdata = pattern_high_reg;
            REG_CARE_BITS:    prdata = {48'd0, care_bits_reg};
            REG_PATTERN_LEN:  prdata = {{(64-LEN_W){1'b0}}, pattern_length_reg};
            default:          prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= 64'd0;
            pattern_high_reg   <= 64'd0;
            care_bits_reg      <= 16'hFFFF;
            pattern_length_reg <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg    <= pwdata;
                REG_PATTERN_HIGH: pattern_high_reg   <= pwdata;
                REG_CARE_BITS:    care_bits_reg      <= pwdata[15:0];
                REG_PATTERN_LEN:  pattern_length_reg <= pwdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Any byte is taken only while the output register is empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign len_eff = (pattern_length_reg > LEN_W'(MAX_PATTERN_BYTES))
                     ? LEN_W'(MAX_PATTERN_BYTES) : pattern_length_reg;
    assign len_sub = (len_eff == '0) ? LEN_W'(1) : len_eff;
    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    assign cell_ctrl.shift_en = in_fire && !match_reported_reg;
    assign cell_ctrl.clear    = in_fire && s_tlast;

    // Cell k holds the byte k steps back; it checks pattern position len-1-k.
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
    begin : g_cell
        logic [7:0]           byte_in;
        logic [WIN_IDX_W-1:0] pat_idx;
        logic [LEN_W-1:0]     pat_idx_wide;
        logic                 in_use;

        if (k == 0)
        begin : g_head
            assign byte_in = s_tdata;
        end
        else
        begin : g_body
            assign byte_in = win[k-1];
        end

        assign in_use       = LEN_W'(k) < len_eff;
        assign pat_idx_wide = len_eff - LEN_W'(1) - LEN_W'(k);
        assign pat_idx      = pat_idx_wide[WIN_IDX_W-1:0];

        mbps_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .byte_in     (byte_in),
            .expect_byte (pattern_all[pat_idx*8 +: 8]),
            .care        (in_use && care_bits_reg[pat_idx]),
            .byte_out    (win[k]),
            .match       (cell_match[k])
        );
    end

    assign all_match   = &cell_match;
    assign count       = {1'b0, bytes_seen_reg} + (OFFSET_W+1)'(1);
    assign offset_wide = count - (OFFSET_W+1)'(len_sub);
    assign hit = (len_eff == '0) || ((count >= (OFFSET_W+1)'(len_eff)) && all_match);
    assign produce = in_fire && !match_reported_reg && (hit || s_tlast);

    always_comb
    begin
        bytes_seen_next     = bytes_seen_reg;
        match_reported_next = match_reported_reg;
        out_valid_next      = out_valid_reg;
        out_found_next      = out_found_reg;
        out_offset_next     = out_offset_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (produce)
        begin
            out_valid_next  = 1'b1;
            out_found_next  = hit;
            out_offset_next = hit ? offset_wide[OFFSET_W-1:0] : '0;
        end

        if (in_fire)
        begin
            if (s_tlast)
            begin
                bytes_seen_next     = '0;
                match_reported_next = 1'b0;
            end
            else if (!match_reported_reg)
            begin
                if (bytes_seen_reg != '1)
                begin
                    bytes_seen_next = bytes_seen_reg + OFFSET_W'(1);
                end
                match_reported_next = hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg     <= '0;
            match_reported_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            bytes_seen_reg     <= bytes_seen_next;
            match_reported_reg <= match_reported_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg  <= out_found_next;
        out_offset_reg <= out_offset_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_offset_reg;

    `MBPS_ASSERT_NEXT(a_region_end_clears, in_fire && s_tlast, (bytes_seen_reg == '0) && !match_reported_reg, "region end did not clear scan state")
    `MBPS_ASSERT_NEXT(a_matched_stays, in_fire && match_reported_reg && !s_tlast, match_reported_reg && (bytes_seen_reg == $past(bytes_seen_reg)), "matched region changed state")
    `MBPS_ASSERT_NEXT(a_count_steps, in_fire && !match_reported_reg && !s_tlast && (bytes_seen_reg != '1), bytes_seen_reg == $past(bytes_seen_reg) + OFFSET_W'(1), "byte count did not advance")
    `MBPS_ASSERT_SAME(a_not_found_zero, out_valid_reg && !out_found_reg, out_offset_reg == '0, "not-found result carries an offset")
    `MBPS_ASSERT_NEXT(a_result_registered, produce, out_valid_reg, "result was not registered")

endmodule
`default_nettype wire
